// ===== design/ole_pkg.sv =====
// Shared types and constants for the ordered list engine.
package ole_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int POS_W          = 5;

    typedef enum logic [2:0] {
        FUNC_INS_FRONT = 3'd0,
        FUNC_INS_AT    = 3'd1,
        FUNC_INS_BACK  = 3'd2,
        FUNC_DEL_FRONT = 3'd3,
        FUNC_DEL_AT    = 3'd4,
        FUNC_DEL_BACK  = 3'd5,
        FUNC_SEARCH    = 3'd6,
        FUNC_LIST      = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        KIND_ELEM   = 2'd0,
        KIND_MATCH  = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_SCAN = 2'd2,
        S_FIN  = 2'd3
    } t_state;

    typedef struct packed {
        t_func                      func;
        logic [POS_W-1:0]           position;
        logic signed [VALUE_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        t_kind                      kind;
        logic signed [VALUE_W-1:0]  item_value;
        logic [POS_W-1:0]           item_position;
        t_status                    status;
        logic                       last;
    } t_res;

endpackage

// ===== design/ordered_list_engine.sv =====
// Ordered list engine top level: command sequencer over a chain of list cells.
//
// A request is taken when start is high and busy is low. Inserts, deletes, and
// a search or list on an empty list hold busy only in the execute state. The
// status result appears in the first cycle that busy is low, and the next
// request can be taken at the end of that cycle. Search and list on a list of
// N > 0 elements hold busy through the execute, scan and finish states. The cell
// chain rotates one element past the head cell per cycle, and each element or
// match result appears in the cycle after its element is examined. The status
// result again appears in the first cycle that busy is low. A search or list
// on a full list of 16 emits up to 17 results. Results are one-cycle strobes
// on o_result_valid and cannot be held off. Every request ends with a status
// result that has last set.
module ordered_list_engine #(
    parameter int LIST_DEPTH = ole_pkg::LIST_DEPTH_DEF,
    parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ole_pkg::t_cmd i_cmd,
    output logic          o_result_valid,
    output ole_pkg::t_res o_result
);
    import ole_pkg::*;

    localparam int IW   = $clog2(LIST_DEPTH);
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_idx, n_idx;
    t_res                 r_res, n_res;
    logic                 r_res_valid, n_res_valid;

    t_cell_op             cell_op;
    logic [IW-1:0]        sel_idx;
    logic [IW-1:0]        last_idx;
    logic signed [DATA_WIDTH-1:0] new_val;
    logic signed [DATA_WIDTH-1:0] w_val [LIST_DEPTH];

    logic [CMPW-1:0]      pos_x;
    logic [CMPW-1:0]      cnt_x;
    logic                 is_full;
    logic                 is_empty;

    assign new_val  = DATA_WIDTH'(r_cmd.value);
    assign last_idx = IW'(r_count - CW'(1));
    assign pos_x    = CMPW'(r_cmd.position);
    assign cnt_x    = CMPW'(r_count);
    assign is_full  = (r_count == CW'(LIST_DEPTH));
    assign is_empty = (r_count == '0);

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic signed [DATA_WIDTH-1:0] left_v;
        logic signed [DATA_WIDTH-1:0] right_v;
        if (g == 0) begin : g_first
            assign left_v = new_val;
        end else begin : g_mid_l
            assign left_v = w_val[g-1];
        end
        if (g == LIST_DEPTH - 1) begin : g_end
            assign right_v = w_val[g];
        end else begin : g_mid_r
            assign right_v = w_val[g+1];
        end
        ole_cell #(
            .CELL_INDEX (g),
            .IW         (IW),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_op       (cell_op),
            .i_sel_idx  (sel_idx),
            .i_last_idx (last_idx),
            .i_new      (new_val),
            .i_left     (left_v),
            .i_right    (right_v),
            .i_head     (w_val[0]),
            .o_value    (w_val[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_idx       = r_idx;
        n_res       = '{kind: KIND_STATUS, item_value: '0, item_position: '0,
                        status: ST_OK, last: 1'b1};
        n_res_valid = 1'b0;
        cell_op     = CELL_HOLD;
        sel_idx     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_cmd.func) inside
                    FUNC_INS_FRONT, FUNC_INS_AT, FUNC_INS_BACK: begin
                        n_res_valid = 1'b1;
                        if (is_full) begin
                            n_res.status = ST_FULL;
                        end else if (r_cmd.func == FUNC_INS_AT &&
                                     (pos_x == '0 || pos_x > cnt_x + CMPW'(1))) begin
                            n_res.status = ST_BADPOS;
                        end else begin
                            cell_op = CELL_INS;
                            if (r_cmd.func == FUNC_INS_AT) begin
                                sel_idx = IW'(pos_x - CMPW'(1));
                            end else if (r_cmd.func == FUNC_INS_BACK) begin
                                sel_idx = IW'(r_count);
                            end
                            n_count = r_count + CW'(1);
                        end
                    end
                    FUNC_DEL_FRONT, FUNC_DEL_AT, FUNC_DEL_BACK: begin
                        n_res_valid = 1'b1;
                        if (is_empty) begin
                            n_res.status = ST_EMPTY;
                        end else if (r_cmd.func == FUNC_DEL_AT &&
                                     (pos_x == '0 || pos_x > cnt_x)) begin
                            n_res.status = ST_BADPOS;
                        end else begin
                            cell_op = CELL_DEL;
                            if (r_cmd.func == FUNC_DEL_AT) begin
                                sel_idx = IW'(pos_x - CMPW'(1));
                            end else if (r_cmd.func == FUNC_DEL_BACK) begin
                                sel_idx = last_idx;
                            end
                            n_count = r_count - CW'(1);
                        end
                    end
                    default: begin
                        if (is_empty) begin
                            n_res_valid  = 1'b1;
                            n_res.status = (r_cmd.func == FUNC_LIST) ? ST_EMPTY : ST_OK;
                        end else begin
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                // examine the head, then rotate the next element into it
                cell_op                = CELL_ROT;
                n_res.last             = 1'b0;
                n_res.item_position    = POS_W'(r_idx) + POS_W'(1);
                if (r_cmd.func == FUNC_LIST) begin
                    n_res_valid      = 1'b1;
                    n_res.kind       = KIND_ELEM;
                    n_res.item_value = VALUE_W'(w_val[0]);
                end else begin
                    n_res_valid = (w_val[0] == new_val);
                    n_res.kind  = KIND_MATCH;
                end
                n_idx = r_idx + IW'(1);
                if (r_idx == last_idx) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_res <= n_res;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

endmodule

// ===== design/ole_cell.sv =====
// One list slot: holds an element and takes a neighbor's value on shifts.
module ole_cell #(
    parameter int CELL_INDEX = 0,
    parameter int IW         = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  ole_pkg::t_cell_op            i_op,
    input  logic [IW-1:0]                i_sel_idx,
    input  logic [IW-1:0]                i_last_idx,
    input  logic signed [DATA_WIDTH-1:0] i_new,
    input  logic signed [DATA_WIDTH-1:0] i_left,
    input  logic signed [DATA_WIDTH-1:0] i_right,
    input  logic signed [DATA_WIDTH-1:0] i_head,
    output logic signed [DATA_WIDTH-1:0] o_value
);
    import ole_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_INDEX);

    logic signed [DATA_WIDTH-1:0] r_value;
    logic signed [DATA_WIDTH-1:0] n_value;

    always_comb begin
        n_value = r_value;
        unique case (i_op)
            CELL_HOLD: n_value = r_value;
            CELL_INS: begin
                if (MY_IDX > i_sel_idx) begin
                    n_value = i_left;
                end else if (MY_IDX == i_sel_idx) begin
                    n_value = i_new;
                end
            end
            CELL_DEL: begin
                if (MY_IDX >= i_sel_idx) begin
                    n_value = i_right;
                end
            end
            CELL_ROT: begin
                // wrap the head around to the tail of the occupied part
                n_value = (MY_IDX == i_last_idx) ? i_head : i_right;
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== dv/ordered_list_engine_tb.sv =====
// Self-checking testbench for the ordered list engine: directed and random command streams.
module ordered_list_engine_tb;
    import ole_pkg::*;

    localparam int LIST_DEPTH = LIST_DEPTH_DEF;

    typedef enum int {MIX_GROW, MIX_EVEN, MIX_SHRINK} t_mix;

    typedef struct {
        t_cmd cmd;
        bit   drain;
    } t_cmd_slot;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_cmd i_cmd   = '0;
    logic o_result_valid;
    t_res o_result;

    // stimulus side
    t_cmd_slot                 cmd_q[$];
    int                        plan_len;
    logic signed [VALUE_W-1:0] key_pool[8];
    int                        n_total;
    int                        n_popped;

    // prediction side
    logic signed [VALUE_W-1:0] stored_vals[LIST_DEPTH];
    int                        stored_len;
    t_res                      results_due[$];
    int                        n_accepted;
    int                        n_errors;

    ordered_list_engine u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic push_result(input t_kind kind, input logic signed [VALUE_W-1:0] val,
                               input int pos, input t_status st, input logic last);
        t_res r;
        r.kind          = kind;
        r.item_value    = val;
        r.item_position = POS_W'(pos);
        r.status        = st;
        r.last          = last;
        results_due.push_back(r);
    endtask

    // Update the list copy for one accepted request and queue its results.
    task automatic run_list_cmd(input t_cmd c);
        t_status st;
        int      idx;
        int      i;
        st = ST_OK;
        case (c.func) inside
            FUNC_INS_FRONT, FUNC_INS_AT, FUNC_INS_BACK: begin
                if (stored_len >= LIST_DEPTH) begin
                    st = ST_FULL;
                end else if (c.func == FUNC_INS_AT &&
                             (c.position < 1 || c.position > stored_len + 1)) begin
                    st = ST_BADPOS;
                end else begin
                    idx = (c.func == FUNC_INS_FRONT) ? 0 :
                          (c.func == FUNC_INS_BACK)  ? stored_len : int'(c.position) - 1;
                    for (i = stored_len; i > idx; i--)
                        stored_vals[i] = stored_vals[i-1];
                    stored_vals[idx] = c.value;
                    stored_len++;
                end
            end
            FUNC_DEL_FRONT, FUNC_DEL_AT, FUNC_DEL_BACK: begin
                if (stored_len == 0) begin
                    st = ST_EMPTY;
                end else if (c.func == FUNC_DEL_AT &&
                             (c.position < 1 || c.position > stored_len)) begin
                    st = ST_BADPOS;
                end else begin
                    idx = (c.func == FUNC_DEL_FRONT) ? 0 :
                          (c.func == FUNC_DEL_BACK)  ? stored_len - 1 : int'(c.position) - 1;
                    for (i = idx; i < stored_len - 1; i++)
                        stored_vals[i] = stored_vals[i+1];
                    stored_len--;
                end
            end
            FUNC_SEARCH: begin
                for (i = 0; i < stored_len; i++)
                    if (stored_vals[i] == c.value)
                        push_result(KIND_MATCH, '0, i + 1, ST_OK, 1'b0);
            end
            default: begin
                if (stored_len == 0)
                    st = ST_EMPTY;
                for (i = 0; i < stored_len; i++)
                    push_result(KIND_ELEM, stored_vals[i], i + 1, ST_OK, 1'b0);
            end
        endcase
        push_result(KIND_STATUS, '0, 0, st, 1'b1);
    endtask

    // Queue a request and track the list length it leaves behind.
    task automatic queue_cmd(input t_func f, input int p,
                             input logic signed [VALUE_W-1:0] v, input bit drain);
        t_cmd_slot s;
        s.cmd.func     = f;
        s.cmd.position = POS_W'(p);
        s.cmd.value    = v;
        s.drain        = drain;
        cmd_q.push_back(s);
        case (f) inside
            FUNC_INS_FRONT, FUNC_INS_BACK:
                if (plan_len < LIST_DEPTH) plan_len++;
            FUNC_INS_AT:
                if (plan_len < LIST_DEPTH && s.cmd.position >= 1 &&
                    s.cmd.position <= plan_len + 1) plan_len++;
            FUNC_DEL_FRONT, FUNC_DEL_BACK:
                if (plan_len > 0) plan_len--;
            FUNC_DEL_AT:
                if (plan_len > 0 && s.cmd.position >= 1 &&
                    s.cmd.position <= plan_len) plan_len--;
            default: ;
        endcase
    endtask

    // Driver: retire the accepted request, then decide whether to present the next one.
    always @(negedge i_clk) begin
        bit send;
        int idle_pct;
        send = 1'b0;
        if (n_accepted > n_popped) begin
            void'(cmd_q.pop_front());
            n_popped++;
        end
        idle_pct = (n_popped < n_total / 3)     ? 11 :
                   (n_popped < 2 * n_total / 3) ? 73 : 0;
        if (i_rst_n && cmd_q.size() != 0) begin
            if (cmd_q[0].drain && results_due.size() != 0)
                send = 1'b0;
            else
                send = ($urandom_range(99) >= idle_pct);
        end
        start <= send;
        if (send)
            i_cmd <= cmd_q[0].cmd;
    end

    // Monitor: check results first, then predict for a request taken at this edge.
    always @(posedge i_clk) begin
        t_res due;
        if (i_rst_n) begin
            if (o_result_valid === 1'b1) begin
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %p", o_result));
                end else begin
                    due = results_due.pop_front();
                    check_field("kind", o_result.kind, due.kind);
                    check_field("item_value", o_result.item_value, due.item_value);
                    check_field("item_position", o_result.item_position, due.item_position);
                    check_field("status", o_result.status, due.status);
                    check_field("last", o_result.last, due.last);
                end
            end
            if (start && busy === 1'b0) begin
                run_list_cmd(i_cmd);
                n_accepted++;
            end
        end
    end

    initial begin
        int                        k;
        int                        r;
        int                        ins_lim;
        int                        del_lim;
        t_mix                      mix;
        t_func                     f;
        int                        p;
        logic signed [VALUE_W-1:0] v;

        for (k = 0; k < 8; k++)
            key_pool[k] = $urandom;

        // empty list: every delete and list report empty, search is still ok
        queue_cmd(FUNC_LIST,      0, 0, 1'b0);
        queue_cmd(FUNC_DEL_FRONT, 0, 0, 1'b0);
        queue_cmd(FUNC_DEL_AT,    0, 0, 1'b0);
        queue_cmd(FUNC_DEL_BACK,  0, 0, 1'b0);
        queue_cmd(FUNC_SEARCH,    0, 0, 1'b0);
        queue_cmd(FUNC_INS_AT,    0, 7, 1'b0);
        queue_cmd(FUNC_INS_AT,    2, 7, 1'b0);
        // position 1 on empty, then the value extremes, append via count+1
        queue_cmd(FUNC_INS_AT,    1, 32'sh7fffffff, 1'b0);
        queue_cmd(FUNC_INS_FRONT, 0, 32'sh80000000, 1'b0);
        queue_cmd(FUNC_INS_BACK,  0, 0, 1'b0);
        queue_cmd(FUNC_INS_AT,    4, -1, 1'b0);
        queue_cmd(FUNC_SEARCH,    0, -1, 1'b0);
        queue_cmd(FUNC_LIST,      0, 0, 1'b0);
        queue_cmd(FUNC_DEL_AT,    0, 0, 1'b0);
        queue_cmd(FUNC_DEL_AT,    5, 0, 1'b0);
        queue_cmd(FUNC_DEL_AT,    4, 0, 1'b0);
        queue_cmd(FUNC_DEL_BACK,  0, 0, 1'b0);
        queue_cmd(FUNC_DEL_FRONT, 0, 0, 1'b0);
        // fill to the top with repeated keys, then hit the full list
        for (k = 0; k < LIST_DEPTH - 1; k++)
            queue_cmd((k % 3 == 0) ? FUNC_INS_FRONT : (k % 3 == 1) ? FUNC_INS_BACK : FUNC_INS_AT,
                      2, (k % 2 == 0) ? 5 : $urandom, 1'b0);
        queue_cmd(FUNC_INS_AT,    31, 1, 1'b0);
        queue_cmd(FUNC_INS_FRONT, 0, 1, 1'b0);
        queue_cmd(FUNC_INS_BACK,  0, 1, 1'b0);
        queue_cmd(FUNC_SEARCH,    0, 5, 1'b0);
        queue_cmd(FUNC_LIST,      0, 0, 1'b0);

        for (k = 0; k < 420; k++) begin
            case ((k / 30) % 4)
                0:       mix = MIX_SHRINK;
                2:       mix = MIX_GROW;
                default: mix = MIX_EVEN;
            endcase
            ins_lim = (mix == MIX_GROW) ? 70 : (mix == MIX_SHRINK) ? 15 : 40;
            del_lim = ins_lim + ((mix == MIX_GROW) ? 20 : (mix == MIX_SHRINK) ? 70 : 40);
            r = $urandom_range(99);
            if (r < ins_lim)
                f = t_func'(FUNC_INS_FRONT + $urandom_range(2));
            else if (r < del_lim)
                f = t_func'(FUNC_DEL_FRONT + $urandom_range(2));
            else if (r < del_lim + (100 - del_lim) / 2)
                f = FUNC_SEARCH;
            else
                f = FUNC_LIST;

            if ($urandom_range(9) < 8 && f == FUNC_INS_AT && plan_len < LIST_DEPTH)
                p = $urandom_range(plan_len + 1, 1);
            else if ($urandom_range(9) < 8 && f == FUNC_DEL_AT && plan_len > 0)
                p = $urandom_range(plan_len, 1);
            else
                p = $urandom_range(31);

            r = $urandom_range(9);
            if (r < 5)
                v = key_pool[$urandom_range(7)];
            else if (r < 8)
                v = $urandom;
            else
                case ($urandom_range(3))
                    0:       v = 32'sh80000000;
                    1:       v = 32'sh7fffffff;
                    2:       v = 0;
                    default: v = -1;
                endcase

            // hold off a few requests until the engine has drained
            queue_cmd(f, p, v, (k == 0 || k == 140 || k == 280));
        end
        n_total = cmd_q.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total) @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (n_errors == 0)
            $display("PASS ordered_list_engine");
        else
            $display("FAIL ordered_list_engine");
        $finish;
    end

    initial begin
        #1000000;
        $display("FAIL ordered_list_engine");
        $finish;
    end

endmodule

// ===== sim.f =====
design/ole_pkg.sv
design/ole_cell.sv
design/ordered_list_engine.sv
dv/ordered_list_engine_tb.sv
